// ===== rtl/sld_pkg.sv =====
// Shared constants and types for the staff-line row detector.
// Register indexes, reset values and stream widths; no dependencies.
package sld_pkg;

  localparam int unsigned MAX_DIMENSION_DEF = 4096;

  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned PIXEL_W    = 8;
  localparam int unsigned FRAC_W     = 9;
  localparam int unsigned START_W    = 12;
  localparam int unsigned THICK_W    = 13;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [FRAC_W-1:0]     FRAC_RST   = 9'd179;
  localparam logic [PIXEL_W-1:0]    DARK_RST   = 8'd50;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_FILL_FRAC    = 2'd2,
    REG_DARK_LEVEL   = 2'd3
  } cfg_reg_t;

endpackage

// ===== rtl/staff_line_row_detector_core.sv =====
// Staff-line row detector: horizontal projection of dark pixels per row.
// Top level with config registers, row/run tracking and output skid stage.
// Depends on sld_pkg.
//
//  channel  | ports                            | content
//  ---------+----------------------------------+-----------------------------------
//  input    | in_tvalid/in_tready/in_tdata     | pixel [7:0]
//  result   | out_tvalid/out_tready/out_tdata  | line_start_row [11:0], thickness [24:12]
//  config   | cfg_wr_en/cfg_addr/cfg_wdata     | register index, value
//
// One pixel per cycle while in_tready is high. The row test is combinational
// (one small multiply and compare); a run's result is registered by its closing pixel.
// Reset (synchronous, rst_n low) restores register defaults and clears all counters.
// A stalled result sits in the output register; a second one parks in the skid
// register and in_tready drops until it has moved on.
module staff_line_row_detector_core #(
  parameter int unsigned MAX_DIMENSION = sld_pkg::MAX_DIMENSION_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sld_pkg::IN_TDATA_W-1:0]   in_tdata,   // [7:0] pixel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sld_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [11:0] line_start_row,
                                                       // [24:12] line_rows
  input  logic                             cfg_wr_en,
  input  logic [sld_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [sld_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import sld_pkg::*;

  localparam int unsigned DIM_W = $clog2(MAX_DIMENSION + 1);
  localparam int unsigned POS_W = $clog2(MAX_DIMENSION);
  localparam int unsigned QW    = DIM_W + FRAC_W;
  localparam int unsigned RES_W = START_W + THICK_W;

  // configuration registers
  logic [CFG_DATA_W-1:0] width_r, height_r;
  logic [FRAC_W-1:0]     frac_r;
  logic [PIXEL_W-1:0]    dark_r;

  // frame state
  logic [POS_W-1:0] col_r, col_nxt;
  logic [POS_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] cnt_r, cnt_nxt;
  logic             run_act_r, run_act_nxt;
  logic [POS_W-1:0] run_first_r, run_first_nxt;
  logic [DIM_W-1:0] run_len_r, run_len_nxt;

  // output stage
  logic             out_vld_r, out_vld_nxt;
  logic [RES_W-1:0] out_dat_r, out_dat_nxt;
  logic             skid_vld_r, skid_vld_nxt;
  logic [RES_W-1:0] skid_dat_r, skid_dat_nxt;

  logic             accept;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [DIM_W-1:0] cnt_inc, col_inc, row_inc;
  logic [QW-1:0]    lhs, thr;
  logic             row_end, frame_end, qualify, emit;
  logic [RES_W-1:0] res;

  assign in_tready  = ~skid_vld_r;
  assign accept     = in_tvalid & in_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, out_dat_r};

  always_comb begin
    // zero acts as one, oversize acts as the maximum
    if (width_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (32'(width_r) > MAX_DIMENSION) begin
      w_eff = DIM_W'(MAX_DIMENSION);
    end else begin
      w_eff = DIM_W'(width_r);
    end
    if (height_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (32'(height_r) > MAX_DIMENSION) begin
      h_eff = DIM_W'(MAX_DIMENSION);
    end else begin
      h_eff = DIM_W'(height_r);
    end
  end

  always_comb begin
    cnt_inc   = cnt_r + DIM_W'(in_tdata[PIXEL_W-1:0] < dark_r);
    col_inc   = DIM_W'(col_r) + DIM_W'(1);
    row_inc   = DIM_W'(row_r) + DIM_W'(1);
    row_end   = ~(col_inc < w_eff);
    frame_end = row_end & ~(row_inc < h_eff);
    lhs       = QW'({cnt_inc, 8'd0});
    thr       = QW'(w_eff) * QW'(frac_r);
    qualify   = lhs >= thr;

    col_nxt       = col_r;
    row_nxt       = row_r;
    cnt_nxt       = cnt_r;
    run_act_nxt   = run_act_r;
    run_first_nxt = run_first_r;
    run_len_nxt   = run_len_r;
    emit          = 1'b0;
    res           = {THICK_W'(run_len_r), START_W'(run_first_r)};

    if (accept) begin
      if (!row_end) begin
        col_nxt = POS_W'(col_inc);
        cnt_nxt = cnt_inc;
      end else begin
        col_nxt = '0;
        cnt_nxt = '0;
        if (qualify) begin
          if (run_act_r) begin
            run_len_nxt = run_len_r + DIM_W'(1);
          end else begin
            run_act_nxt   = 1'b1;
            run_first_nxt = row_r;
            run_len_nxt   = DIM_W'(1);
          end
        end else if (run_act_r) begin
          emit        = 1'b1;
          run_act_nxt = 1'b0;
        end
        if (!frame_end) begin
          row_nxt = POS_W'(row_inc);
        end else begin
          // close any open run at frame end, then clear the run
          if (run_act_nxt) begin
            emit = 1'b1;
            res  = {THICK_W'(run_len_nxt), START_W'(run_first_nxt)};
          end
          row_nxt       = '0;
          run_act_nxt   = 1'b0;
          run_first_nxt = '0;
          run_len_nxt   = '0;
        end
      end
    end
  end

  // output register with skid stage behind it
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_dat_nxt  = out_dat_r;
    skid_vld_nxt = skid_vld_r;
    skid_dat_nxt = skid_dat_r;
    if (skid_vld_r) begin
      if (out_tready) begin
        out_dat_nxt  = skid_dat_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (!out_vld_r || out_tready) begin
      out_vld_nxt = emit;
      if (emit) begin
        out_dat_nxt = res;
      end
    end else if (emit) begin
      // hold the waiting result, park the new one
      skid_vld_nxt = 1'b1;
      skid_dat_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WIDTH_RST;
      height_r    <= HEIGHT_RST;
      frac_r      <= FRAC_RST;
      dark_r      <= DARK_RST;
      col_r       <= '0;
      row_r       <= '0;
      cnt_r       <= '0;
      run_act_r   <= 1'b0;
      run_first_r <= '0;
      run_len_r   <= '0;
      out_vld_r   <= 1'b0;
      skid_vld_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_reg_t'(cfg_addr))
          REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
          REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
          REG_FILL_FRAC:    frac_r   <= cfg_wdata[FRAC_W-1:0];
          REG_DARK_LEVEL:   dark_r   <= cfg_wdata[PIXEL_W-1:0];
          default: ;
        endcase
      end
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      cnt_r       <= cnt_nxt;
      run_act_r   <= run_act_nxt;
      run_first_r <= run_first_nxt;
      run_len_r   <= run_len_nxt;
      out_vld_r   <= out_vld_nxt;
      skid_vld_r  <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_dat_r  <= out_dat_nxt;
    skid_dat_r <= skid_dat_nxt;
  end

endmodule

// ===== rtl/sld_checker.sv =====
// Port-level checks for the staff-line row detector, bound to the top level.
// Depends on sld_pkg and staff_line_row_detector_core.
module sld_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [sld_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import sld_pkg::*;

  // a stalled transfer keeps its valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result valid dropped while stalled");

  // a stalled transfer keeps its data
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result data changed while stalled");

  // reset leaves no result pending and the input open
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("reset did not clear the output stage");

  // every line reported is at least one row thick
  a_thick_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[START_W+THICK_W-1:START_W] != '0)
    else $error("zero line thickness reported");

  // input only stalls while a result is held back
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no pending result");

endmodule

bind staff_line_row_detector_core sld_checker u_sld_checker (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for staff_line_row_detector_core: streams grey frames, predicts
// staff lines in a scoreboard class and checks every result transfer.
// Depends on sld_pkg and the core RTL.

module testbench;
  import sld_pkg::*;

  typedef struct packed {
    logic [START_W-1:0] start_row;
    logic [THICK_W-1:0] thickness;
  } staff_line_t;

  class line_scoreboard;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [FRAC_W-1:0]     fill_frac;
    logic [PIXEL_W-1:0]    dark_level;
    logic [START_W-1:0]    col_pos;
    logic [START_W-1:0]    row_pos;
    logic [START_W-1:0]    first_row;
    logic [THICK_W-1:0]    dark_cnt;
    logic [THICK_W-1:0]    run_len;
    bit                    run_on;
    staff_line_t           pending_lines[$];
    int unsigned           errors;
    int unsigned           lines_predicted;

    function new();
      width_reg       = WIDTH_RST;
      height_reg      = HEIGHT_RST;
      fill_frac       = FRAC_RST;
      dark_level      = DARK_RST;
      col_pos         = '0;
      row_pos         = '0;
      first_row       = '0;
      dark_cnt        = '0;
      run_len         = '0;
      run_on          = 1'b0;
      errors          = 0;
      lines_predicted = 0;
    endfunction

    function int unsigned clamp_dim(logic [CFG_DATA_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIMENSION_DEF) return MAX_DIMENSION_DEF;
      return 32'(v);
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_IMAGE_WIDTH:  width_reg  = v;
        REG_IMAGE_HEIGHT: height_reg = v;
        REG_FILL_FRAC:    fill_frac  = v[FRAC_W-1:0];
        REG_DARK_LEVEL:   dark_level = v[PIXEL_W-1:0];
        default: ;
      endcase
    endfunction

    function void push_line();
      staff_line_t ln;
      ln.start_row = first_row;
      ln.thickness = run_len;
      pending_lines.insert(pending_lines.size(), ln);
      lines_predicted++;
    endfunction

    // Advance the row/run tracking by one accepted pixel.
    function void note_pixel(logic [PIXEL_W-1:0] px);
      int unsigned w;
      int unsigned h;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      if (px < dark_level) dark_cnt++;
      if (32'(col_pos) + 1 < w) begin
        col_pos++;
        return;
      end
      if (32'(dark_cnt) * 256 >= w * 32'(fill_frac)) begin
        if (run_on) begin
          run_len++;
        end else begin
          run_on    = 1'b1;
          first_row = row_pos;
          run_len   = THICK_W'(1);
        end
      end else if (run_on) begin
        push_line();
        run_on = 1'b0;
      end
      col_pos  = '0;
      dark_cnt = '0;
      if (32'(row_pos) + 1 < h) begin
        row_pos++;
        return;
      end
      // frame end: close any open run and clear the run
      if (run_on) push_line();
      row_pos   = '0;
      run_on    = 1'b0;
      first_row = '0;
      run_len   = '0;
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= 10)
        $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    endfunction

    function void check_line(logic [OUT_TDATA_W-1:0] td);
      staff_line_t want;
      staff_line_t seen;
      seen.start_row = td[START_W-1:0];
      seen.thickness = td[START_W+THICK_W-1:START_W];
      if (pending_lines.size() == 0) begin
        flag("line with none pending, start row", 32'd0, 32'(seen.start_row));
        return;
      end
      want = pending_lines.pop_front();
      if (seen.start_row !== want.start_row)
        flag("start row", 32'(want.start_row), 32'(seen.start_row));
      if (seen.thickness !== want.thickness)
        flag("thickness", 32'(want.thickness), 32'(seen.thickness));
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [7:0] pixel
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [11:0] line_start_row, [24:12] line_rows
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  line_scoreboard sb = new();
  bit             no_idle = 1'b0;
  bit             squeeze = 1'b0;
  int unsigned    gen_col = 0;
  bit             row_dark = 1'b0;

  staff_line_row_detector_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // Offer one pixel and hold it until the transfer; tvalid stays high on return.
  task automatic send_pixel(input logic [PIXEL_W-1:0] px);
    if (!no_idle && $urandom_range(0, 99) < 33) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 33);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_pixel(px);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  // Drain outstanding lines, let the pipeline settle, then load all four registers.
  task automatic program_regs(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                              input logic [FRAC_W-1:0] f, input logic [PIXEL_W-1:0] d);
    in_tvalid <= 1'b0;
    while (sb.pending_lines.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_FILL_FRAC, CFG_DATA_W'(f));
    write_reg(REG_DARK_LEVEL, CFG_DATA_W'(d));
    cfg_wr_en <= 1'b0;
    gen_col = 0;
  endtask

  // Rows are mostly dark or mostly light so that runs of qualifying rows form.
  function automatic logic [PIXEL_W-1:0] pick_pixel(int unsigned w_eff, logic [PIXEL_W-1:0] lvl);
    if (gen_col == 0) row_dark = ($urandom_range(0, 99) < 55);
    gen_col = (gen_col + 1 >= w_eff) ? 0 : gen_col + 1;
    if ($urandom_range(0, 9) == 0 || (row_dark && lvl == 0)) return PIXEL_W'($urandom_range(0, 255));
    if (row_dark) return PIXEL_W'($urandom_range(0, lvl - 1));
    return PIXEL_W'($urandom_range(lvl, 255));
  endfunction

  initial begin : receiver
    int unsigned hold;
    bit          held_once;
    hold      = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        sb.check_line(out_tdata);
      end
      if (hold > 0) begin
        hold--;
      end else if (!held_once && squeeze) begin
        // long hold-off: let the core fill up and drop in_tready
        hold      = 300;
        held_once = 1'b1;
      end
      out_tready <= (hold == 0) && (no_idle || $urandom_range(0, 99) >= 33);
    end
  end

  initial begin : stimulus
    int unsigned           phase;
    int unsigned           n_items;
    int unsigned           random_items;
    int unsigned           w_eff;
    logic [CFG_DATA_W-1:0] w_val;
    logic [CFG_DATA_W-1:0] h_val;
    logic [FRAC_W-1:0]     f_val;
    logic [PIXEL_W-1:0]    d_val;
    random_items = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero width acts as one: every pixel is a row, zero fraction qualifies all
    program_regs(13'd0, 13'd3, 9'd0, 8'd0);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd128);
    // zero height acts as one, full fraction needs every pixel dark
    program_regs(13'd2, 13'd0, 9'd256, 8'd255);
    send_pixel(8'd0);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd0);
    // fraction above one: nothing can qualify
    program_regs(13'd1, 13'd2, 9'd511, 8'd200);
    send_pixel(8'd0);
    send_pixel(8'd0);
    // run closed by a light row, then a run closed by the frame end
    program_regs(13'd4, 13'd4, 9'd128, 8'd128);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        send_pixel((r == 2) ? 8'd200 : ((c == 0) ? 8'd255 : 8'd127));
    // one line per pixel while the receiver holds off, so the core fills and stalls
    program_regs(13'd1, 13'd1, 9'd0, 8'd128);
    squeeze = 1'b1;
    repeat (40) send_pixel(8'd0);
    squeeze = 1'b0;

    for (phase = 0; phase < 400 && random_items < 690; phase++) begin
      n_items = $urandom_range(10, 60);
      case ($urandom_range(0, 99)) inside
        [0:4]:   w_val = 13'd0;
        [5:9]:   w_val = 13'd1;
        default: w_val = CFG_DATA_W'($urandom_range(2, 8));
      endcase
      h_val = ($urandom_range(0, 99) < 5) ? 13'd0 : CFG_DATA_W'($urandom_range(1, 8));
      case ($urandom_range(0, 9))
        0:       f_val = 9'd0;
        1:       f_val = 9'd256;
        2:       f_val = FRAC_W'($urandom_range(257, 511));
        default: f_val = FRAC_W'($urandom_range(64, 250));
      endcase
      case ($urandom_range(0, 19))
        0:       d_val = 8'd0;
        1:       d_val = 8'd255;
        default: d_val = PIXEL_W'($urandom_range(1, 254));
      endcase
      if (phase == 3) begin
        // oversized width clamps to the maximum row length; the row stays open
        w_val = 13'h1FFF;
        h_val = 13'd1;
      end else if (phase == 6) begin
        // oversized height, every row qualifies: the line stays open into the next phase
        w_val = 13'd1;
        h_val = 13'h1FFF;
        f_val = 9'd0;
      end
      no_idle = (phase >= 8 && phase < 14);
      program_regs(w_val, h_val, f_val, d_val);
      w_eff = sb.clamp_dim(w_val);
      repeat (n_items) send_pixel(pick_pixel(w_eff, d_val));
      random_items += n_items;
    end

    no_idle = 1'b0;
    in_tvalid <= 1'b0;
    while (sb.pending_lines.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.errors == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/sld_pkg.sv
rtl/staff_line_row_detector_core.sv
rtl/sld_checker.sv
bench/testbench.sv
